// ===== rtl/qau_pkg.sv =====
// shared types, opcodes and helpers of the quaternion arithmetic unit
`timescale 1ns / 1ps

package qau_pkg;

    // opcodes
    localparam logic [3:0] OP_MUL    = 4'd0;
    localparam logic [3:0] OP_ADD    = 4'd1;
    localparam logic [3:0] OP_SUB    = 4'd2;
    localparam logic [3:0] OP_CONJ   = 4'd3;
    localparam logic [3:0] OP_NEG    = 4'd4;
    localparam logic [3:0] OP_SCALE  = 4'd5;
    localparam logic [3:0] OP_DIV    = 4'd6;
    localparam logic [3:0] OP_DOT    = 4'd7;
    localparam logic [3:0] OP_LENGTH = 4'd8;
    localparam logic [3:0] OP_NORM   = 4'd9;
    localparam logic [3:0] OP_LERP   = 4'd10;
    localparam logic [3:0] OP_MATRIX = 4'd11;

    // pipeline shape: square root and divider sections
    localparam int SQ_STAGES   = 9;
    localparam int SQ_STEPS    = 4;
    localparam int DV_STAGES   = 8;
    localparam int DV_STEPS    = 4;
    localparam int LATE_STAGES = SQ_STAGES + 1 + DV_STAGES;

    // matrix row indices of the first and final rows
    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    typedef logic signed [31:0] q_t;
    typedef logic signed [55:0] wide_t;
    typedef q_t [3:0] quat_t;

    localparam wide_t WONE = 56'sd65536;
    localparam wide_t WMAX = 56'sd2147483647;
    localparam wide_t WMIN = -56'sd2147483648;
    localparam q_t    QMAX = 32'sh7fffffff;
    localparam q_t    QMIN = 32'sh80000000;

    typedef struct packed {
        logic [3:0]        opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
        logic signed [31:0] scalar;
    } qau_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               last;
    } qau_out_t;

    // finished item leaving the datapath: up to three rows
    typedef struct packed {
        logic            matrix;
        quat_t [2:0]     row;
    } res_t;

    function automatic q_t sat32(input wide_t v);
        q_t r;
        if (v > WMAX)
            r = QMAX;
        else if (v < WMIN)
            r = QMIN;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic wide_t wx(input q_t v);
        return {{24{v[31]}}, v};
    endfunction

endpackage

// ===== rtl/qau_datapath.sv =====
// pipelined datapath: multiplier bank, sums, square root and dividers
`timescale 1ns / 1ps

module qau_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  qau_pkg::qau_in_t in_data,
    output logic             tail_valid,
    output qau_pkg::res_t    tail_res
);
    import qau_pkg::*;

    typedef struct packed {
        logic [3:0]        op;
        quat_t             a;
        q_t                s;
        quat_t [2:0]       rows;
        logic [39:0]       rem;
        logic [35:0]       root;
        logic [71:0]       rad;
        logic [32:0]       len;
        logic [32:0]       d;
        logic [3:0][33:0]  r;
        logic [3:0][31:0]  nb;
        logic [3:0][31:0]  q;
        logic [3:0]        ovf;
        logic [3:0]        neg;
    } late_t;

    function automatic logic signed [32:0] sx33(input q_t v);
        return {v[31], v};
    endfunction

    // stage 0: input beat
    qau_in_t s0_reg, s1_reg, s2_reg;
    logic    s0v_reg, s1v_reg, s2v_reg, s3v_reg;
    quat_t   s0_a, s0_b;
    logic signed [32:0] k0;
    logic signed [32:0] opa [4][4];
    logic signed [32:0] opb [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0v_reg <= 1'b0;
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
            s3v_reg <= 1'b0;
        end
        else if (en)
        begin
            s0v_reg <= in_valid;
            s1v_reg <= s0v_reg;
            s2v_reg <= s1v_reg;
            s3v_reg <= s2v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg <= in_data;
            s1_reg <= s0_reg;
            s2_reg <= s1_reg;
        end
    end

    assign s0_a = {s0_reg.a_w, s0_reg.a_z, s0_reg.a_y, s0_reg.a_x};
    assign s0_b = {s0_reg.b_w, s0_reg.b_z, s0_reg.b_y, s0_reg.b_x};
    assign k0   = 33'sd65536 - sx33(s0_reg.scalar);

    // operand steering for the 4x4 multiplier bank
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                opa[i][j] = sx33(s0_a[i]);
                opb[i][j] = sx33(s0_b[j]);
                case (s0_reg.opcode) inside
                    OP_LENGTH, OP_NORM, OP_MATRIX: opb[i][j] = sx33(s0_a[j]);
                    OP_SCALE: opb[i][j] = sx33(s0_reg.scalar);
                    OP_LERP:
                    begin
                        if (j == ((i + 1) % 4))
                            opb[i][j] = k0;
                        else if (j == ((i + 2) % 4))
                        begin
                            opa[i][j] = sx33(s0_b[i]);
                            opb[i][j] = sx33(s0_reg.scalar);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // stage 1: raw products
    logic signed [65:0] prod_reg [4][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    prod_reg[i][j] <= opa[i][j] * opb[i][j];
        end
    end

    // stage 2: floor to q16.16, product sums, square sum
    wide_t fl [4][4];
    wide_t fl_reg [4][4];
    wide_t [3:0] mulr, mulr_reg, nbs, nbs_reg;
    wide_t dot, dot_reg;
    logic [65:0] sqsum, sqsum_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                fl[i][j] = wide_t'(prod_reg[i][j] >>> 16);
        mulr[0] = fl[0][3] + fl[1][2] - fl[2][1] + fl[3][0];
        mulr[1] = -fl[0][2] + fl[1][3] + fl[2][0] + fl[3][1];
        mulr[2] = fl[0][1] - fl[1][0] + fl[2][3] + fl[3][2];
        mulr[3] = -fl[0][0] - fl[1][1] - fl[2][2] + fl[3][3];
        dot = fl[0][0] + fl[1][1] + fl[2][2] + fl[3][3];
        sqsum = '0;
        for (int i = 0; i < 4; i++)
        begin
            // floor of the negated product
            nbs[i] = -fl[i][(i + 2) % 4]
                     - ((prod_reg[i][(i + 2) % 4][15:0] != 16'd0) ? 56'sd1 : 56'sd0);
            sqsum = sqsum + {2'b00, prod_reg[i][i][63:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fl_reg    <= fl;
            mulr_reg  <= mulr;
            nbs_reg   <= nbs;
            dot_reg   <= dot;
            sqsum_reg <= sqsum;
        end
    end

    // stage 3: per-opcode result selection and saturation
    quat_t s2_a, s2_b;
    wide_t rw [3][4];
    late_t s3_next, s3_reg;
    wide_t xx, yy, zz, xy, xz, yz, wxx, wy, wz;

    assign s2_a = {s2_reg.a_w, s2_reg.a_z, s2_reg.a_y, s2_reg.a_x};
    assign s2_b = {s2_reg.b_w, s2_reg.b_z, s2_reg.b_y, s2_reg.b_x};
    assign xx  = fl_reg[0][0] <<< 1;
    assign yy  = fl_reg[1][1] <<< 1;
    assign zz  = fl_reg[2][2] <<< 1;
    assign xy  = fl_reg[0][1] <<< 1;
    assign xz  = fl_reg[0][2] <<< 1;
    assign yz  = fl_reg[1][2] <<< 1;
    assign wxx = fl_reg[3][0] <<< 1;
    assign wy  = fl_reg[3][1] <<< 1;
    assign wz  = fl_reg[3][2] <<< 1;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                rw[r][c] = '0;
        case (s2_reg.opcode)
            OP_MUL:
                for (int c = 0; c < 4; c++) rw[0][c] = mulr_reg[c];
            OP_ADD:
                for (int c = 0; c < 4; c++) rw[0][c] = wx(s2_a[c]) + wx(s2_b[c]);
            OP_SUB:
                for (int c = 0; c < 4; c++) rw[0][c] = wx(s2_a[c]) - wx(s2_b[c]);
            OP_CONJ:
            begin
                for (int c = 0; c < 3; c++) rw[0][c] = -wx(s2_a[c]);
                rw[0][3] = wx(s2_a[3]);
            end
            OP_NEG:
                for (int c = 0; c < 4; c++) rw[0][c] = -wx(s2_a[c]);
            OP_SCALE:
                for (int c = 0; c < 4; c++) rw[0][c] = fl_reg[c][c];
            OP_DOT:
                rw[0][3] = dot_reg;
            OP_DIV, OP_LENGTH, OP_NORM: ;
            OP_LERP:
                for (int c = 0; c < 4; c++)
                    rw[0][c] = fl_reg[c][(c + 1) % 4]
                               + (dot_reg < 0 ? nbs_reg[c] : fl_reg[c][(c + 2) % 4]);
            OP_MATRIX:
            begin
                rw[0][0] = WONE - yy - zz;
                rw[0][1] = xy + wz;
                rw[0][2] = xz - wy;
                rw[1][0] = xy - wz;
                rw[1][1] = WONE - xx - zz;
                rw[1][2] = yz + wxx;
                rw[2][0] = xz + wy;
                rw[2][1] = yz - wxx;
                rw[2][2] = WONE - xx - yy;
            end
            default:
                for (int c = 0; c < 4; c++) rw[0][c] = wx(s2_a[c]);
        endcase

        s3_next      = '0;
        s3_next.op   = s2_reg.opcode;
        s3_next.a    = s2_a;
        s3_next.s    = s2_reg.scalar;
        s3_next.rad  = {6'd0, sqsum_reg};
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                s3_next.rows[r][c] = sat32(rw[r][c]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s3_reg <= s3_next;
    end

    // late stages: square root, divider setup, dividers
    late_t late_reg  [LATE_STAGES];
    late_t late_in   [LATE_STAGES];
    late_t late_next [LATE_STAGES];
    logic [LATE_STAGES-1:0] late_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            late_v_reg <= '0;
        else if (en)
            late_v_reg <= {late_v_reg[LATE_STAGES-2:0], s3v_reg};
    end

    assign late_in[0] = s3_reg;

    for (genvar k = 0; k < LATE_STAGES; k++)
    begin : g_late
        if (k > 0)
        begin : g_link
            assign late_in[k] = late_reg[k-1];
        end

        if (k < SQ_STAGES)
        begin : g_sq
            // four binary root digits, two radicand bits each
            always_comb
            begin
                logic [39:0] rem2;
                logic [39:0] trial;
                late_next[k] = late_in[k];
                for (int t = 0; t < SQ_STEPS; t++)
                begin
                    rem2  = {late_next[k].rem[37:0], late_next[k].rad[71:70]};
                    trial = {2'b00, late_next[k].root, 2'b01};
                    late_next[k].rad = {late_next[k].rad[69:0], 2'b00};
                    if (rem2 >= trial)
                    begin
                        late_next[k].rem  = rem2 - trial;
                        late_next[k].root = {late_next[k].root[34:0], 1'b1};
                    end
                    else
                    begin
                        late_next[k].rem  = rem2;
                        late_next[k].root = {late_next[k].root[34:0], 1'b0};
                    end
                end
            end
        end
        else if (k == SQ_STAGES)
        begin : g_prep
            // divisor, magnitudes and overflow check
            always_comb
            begin
                logic [31:0] abs_s;
                logic [31:0] mag;
                late_next[k]     = late_in[k];
                late_next[k].len = late_in[k].root[32:0];
                abs_s = late_in[k].s[31] ? (~late_in[k].s + 32'd1) : late_in[k].s;
                late_next[k].d = (late_in[k].op == OP_DIV) ? {1'b0, abs_s}
                                                           : late_in[k].root[32:0];
                for (int l = 0; l < 4; l++)
                begin
                    mag = late_in[k].a[l][31] ? (~late_in[k].a[l] + 32'd1) : late_in[k].a[l];
                    late_next[k].ovf[l] = {16'd0, mag} >= {late_next[k].d, 15'd0};
                    late_next[k].neg[l] = late_in[k].a[l][31]
                                          ^ ((late_in[k].op == OP_DIV) && late_in[k].s[31]);
                    late_next[k].r[l]  = {18'd0, mag[31:16]};
                    late_next[k].nb[l] = {mag[15:0], 16'd0};
                    late_next[k].q[l]  = '0;
                end
            end
        end
        else
        begin : g_dv
            // four restoring division steps per lane
            always_comb
            begin
                logic [33:0] r2;
                late_next[k] = late_in[k];
                for (int l = 0; l < 4; l++)
                begin
                    for (int t = 0; t < DV_STEPS; t++)
                    begin
                        r2 = {late_next[k].r[l][32:0], late_next[k].nb[l][31]};
                        late_next[k].nb[l] = {late_next[k].nb[l][30:0], 1'b0};
                        if (r2 >= {1'b0, late_next[k].d})
                        begin
                            late_next[k].r[l] = r2 - {1'b0, late_next[k].d};
                            late_next[k].q[l] = {late_next[k].q[l][30:0], 1'b1};
                        end
                        else
                        begin
                            late_next[k].r[l] = r2;
                            late_next[k].q[l] = {late_next[k].q[l][30:0], 1'b0};
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                late_reg[k] <= late_next[k];
        end
    end

    // tail: quotient signs, saturation, length and normalize fixups
    late_t fin;
    quat_t divq;

    assign fin        = late_reg[LATE_STAGES-1];
    assign tail_valid = late_v_reg[LATE_STAGES-1];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (fin.a[l] == 32'sd0)
                divq[l] = '0;
            else if (fin.ovf[l])
                divq[l] = fin.neg[l] ? QMIN : QMAX;
            else
                divq[l] = fin.neg[l] ? (~fin.q[l] + 32'd1) : fin.q[l];
        end
        tail_res.matrix = (fin.op == OP_MATRIX);
        tail_res.row    = fin.rows;
        case (fin.op)
            OP_LENGTH:
                tail_res.row[0][3] = (fin.len[32] || fin.len[31]) ? QMAX : fin.len[31:0];
            OP_DIV:
                tail_res.row[0] = divq;
            OP_NORM:
                tail_res.row[0] = (fin.len == 33'd0) ? fin.a : divq;
            default: ;
        endcase
    end

endmodule

// ===== rtl/quaternion_arithmetic_unit_core.sv =====
// top level of the quaternion arithmetic unit: datapath and output sequencer
//
//  channel | valid     | stall     | data                  | beat
//  --------+-----------+-----------+-----------------------+------------------------
//  request | req_valid | req_stall | req_data (qau_in_t)   | one opcode and operands
//  result  | rsp_valid | rsp_stall | rsp_data (qau_out_t)  | one result or matrix row
//
// one item enters per cycle while req_stall is low; a request beat reaches its first result beat
// through the 36-digit square root and the 32-step dividers, four steps per stage.
// a matrix item holds the result register for three beats, other items one.
// reset clears only valid bits and the row counter.
// the pipeline moves whenever its tail stage is empty or the result register takes it.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  qau_pkg::qau_in_t  req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output qau_pkg::qau_out_t rsp_data
);
    import qau_pkg::*;

    logic       en;
    logic       tail_valid;
    res_t       tail_res;
    logic       o_valid_reg, o_valid_next;
    res_t       o_res_reg;
    logic [1:0] o_row_reg, o_row_next;
    logic       o_done, load;
    quat_t      cur;

    qau_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (req_valid),
        .in_data    (req_data),
        .tail_valid (tail_valid),
        .tail_res   (tail_res)
    );

    // output register frees up on the final beat of an item
    assign o_done    = o_valid_reg && !rsp_stall
                       && (!o_res_reg.matrix || o_row_reg == ROW_LAST);
    assign load      = !o_valid_reg || o_done;
    assign en        = !tail_valid || load;
    assign req_stall = !en;

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_row_next   = o_row_reg;
        if (load)
        begin
            o_valid_next = tail_valid;
            o_row_next   = ROW_FIRST;
        end
        else if (o_valid_reg && !rsp_stall)
            o_row_next = o_row_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            o_row_reg   <= ROW_FIRST;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
            o_row_reg   <= o_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            o_res_reg <= tail_res;
    end

    // result beat
    assign cur             = o_res_reg.row[o_row_reg];
    assign rsp_valid       = o_valid_reg;
    assign rsp_data.out_x  = cur[0];
    assign rsp_data.out_y  = cur[1];
    assign rsp_data.out_z  = cur[2];
    assign rsp_data.out_w  = cur[3];
    assign rsp_data.last   = !o_res_reg.matrix || (o_row_reg == ROW_LAST);

    a_single_row: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_res_reg.matrix |-> o_row_reg == ROW_FIRST)
        else $error("row counter moved on a single-result item");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> o_row_reg == ROW_FIRST || o_row_reg == 2'd1 || o_row_reg == ROW_LAST)
        else $error("matrix row counter out of range");

    a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && rsp_stall && tail_valid |-> req_stall)
        else $error("pipeline advanced into a blocked result register");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !rsp_stall && o_res_reg.matrix && o_row_reg != ROW_LAST
        |=> o_valid_reg && o_row_reg == $past(o_row_reg) + 2'd1)
        else $error("matrix row lost or repeated");

endmodule
